[src/sttbl_pkg.sv]
// ----------------------------------------------------------------------------
// sttbl_pkg: shared types and codes of the software timer table
// Item and result beat layouts, entry layout, command codes, status codes,
// configuration register indexes and the controller state type.
// ----------------------------------------------------------------------------
package sttbl_pkg;

  // Width of a slot number on the result port; it bounds the table at 64 slots.
  localparam int unsigned SLOT_W = 6;

  typedef enum logic [2:0] {
    KIND_TICK          = 3'd0,
    KIND_SET           = 3'd1,
    KIND_QUERY         = 3'd2,
    KIND_RESTART       = 3'd3,
    KIND_RESTART_LAPSE = 3'd4,
    KIND_DELETE        = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_NOT_FOUND  = 2'd2,
    STATUS_NO_RESTART = 2'd3
  } status_e;

  localparam logic [1:0] MODE_HOLD       = 2'd0;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd1;

  localparam logic [1:0] CFG_MS_PER_TICK       = 2'd0;
  localparam logic [1:0] CFG_FRACTION_PER_TICK = 2'd1;
  localparam logic [1:0] CFG_FRACTION_MODULUS  = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tmr_id;
    logic [31:0] lapse;
    logic [1:0]  mode;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              finished;
    logic              running;
    logic [31:0]       now_ms;
  } result_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] start;
    logic [31:0] lapse;
    logic [1:0]  mode;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              eval_en;
    logic [SLOT_W-1:0] ev_slot;
    logic              emit;
  } dp_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

endpackage

[src/software_timer_table.sv]
// ----------------------------------------------------------------------------
// software_timer_table: table of identified software timers
// Millisecond clock with fractional carry and a table of hold, continuous
// and one-shot timers, driven by one command beat at a time.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Every command
// walks the timer table one slot per cycle through the single read port of the
// entry memory, so a command that visits the whole table (tick, query, a set
// into a full table, an unknown id) reads every slot before it returns its
// result, and busy drops in the cycle in which the result is shown, so the next
// command can follow right away. Set, restart and delete stop at the first slot
// that serves them: a hit ends the walk, and the done state then emits the result.
// The result is shown for exactly one cycle with result_valid_o high; there
// is no way to hold it off, so the receiver must take it in that cycle. The
// configuration channel is always ready and is meant to be written only while
// the block is idle. Table contents come out of reset as free slots, so no
// clearing pass is needed.
module software_timer_table #(
  parameter int unsigned TABLE_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  sttbl_pkg::item_t   item_i,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // Result strobe.
  output sttbl_pkg::result_t result_o,
  output logic               result_valid_o
);
  import sttbl_pkg::*;

  dp_ctl_t ctl;
  logic    eval_hit;

  // Each register write lands in its register directly, so the channel never pushes back.
  assign cfg_ready_o = 1'b1;

  // The controller owns sequencing: accept, walk the slots, emit.
  sttbl_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .eval_hit_i (eval_hit),
    .ctl_o      (ctl)
  );

  // The datapath owns the clock, the registers, the entries and the result.
  sttbl_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .eval_hit_o     (eval_hit),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

[src/sttbl_ctrl.sv]
// ----------------------------------------------------------------------------
// sttbl_ctrl: sequencer of the software timer table
// Accepts a command, walks the table one slot per cycle and ends the walk
// early on a hit, then asks the datapath to emit the result.
// ----------------------------------------------------------------------------
module sttbl_ctrl #(
  parameter int unsigned TABLE_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               eval_hit_i,
  output sttbl_pkg::dp_ctl_t ctl_o
);
  import sttbl_pkg::*;

  localparam int unsigned IdxW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SIZE - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] ev_idx_q, ev_idx_d;
  logic [IdxW-1:0] nxt_idx;
  logic            last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ev_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      ev_idx_q <= ev_idx_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ev_idx_d = ev_idx_q;
    ctl_o    = '0;
    nxt_idx  = ev_idx_q + 1'b1;
    last     = (ev_idx_q == LastIdx);
    busy_o   = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load    = 1'b1;
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_slot = '0;
          ev_idx_d      = '0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.eval_en = 1'b1;
        ctl_o.ev_slot = SLOT_W'(ev_idx_q);
        if (eval_hit_i || last) begin
          state_d = ST_DONE;
        end else begin
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_slot = SLOT_W'(nxt_idx);
          ev_idx_d      = nxt_idx;
        end
      end
      ST_DONE: begin
        ctl_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ctl_o.rd_en) |=> (ev_idx_q == $past(nxt_idx)))
    else $error("table walk skipped a slot");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last) |=> (state_q == ST_DONE))
    else $error("table walk ran past the last slot");

endmodule

[src/sttbl_dp.sv]
// ----------------------------------------------------------------------------
// sttbl_dp: datapath of the software timer table
// Holds the configuration, the millisecond clock, the entry memory and the
// result register, and evaluates one slot per cycle under controller command.
// ----------------------------------------------------------------------------
module sttbl_dp #(
  parameter int unsigned TABLE_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sttbl_pkg::dp_ctl_t ctl_i,
  output logic               eval_hit_o,
  input  sttbl_pkg::item_t   item_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output sttbl_pkg::result_t result_o,
  output logic               result_valid_o
);
  import sttbl_pkg::*;

  localparam int unsigned IdxW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic [7:0]        ms_per_tick_q, frac_per_tick_q, frac_mod_q;
  logic [31:0]       clock_ms_q;
  logic [7:0]        clock_frac_q;
  item_t             item_q;
  entry_t            mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] slot_vld_q;
  entry_t            rd_ent_q;
  logic              rd_vld_q;
  status_e           status_q;
  logic [SLOT_W-1:0] slot_q;
  logic              fin_q;
  result_t           result_q;
  logic              result_valid_q;

  logic [IdxW-1:0] rd_idx, ev_idx;
  logic [7:0]      frac_sum, frac_next;
  logic [31:0]     ms_next;
  logic            carry;
  entry_t          ent, wr_ent, freed;
  logic            wr_en, elapsed, id_match, query_hit;
  status_e         hit_status, load_status;

  assign rd_idx = ctl_i.rd_slot[IdxW-1:0];
  assign ev_idx = ctl_i.ev_slot[IdxW-1:0];

  // Clock advance of a tick: whole step, then at most one carry from the fraction.
  always_comb begin
    frac_sum  = clock_frac_q + frac_per_tick_q;
    carry     = (frac_sum >= frac_mod_q);
    frac_next = carry ? (frac_sum - frac_mod_q) : frac_sum;
    ms_next   = clock_ms_q + {24'd0, ms_per_tick_q} + {31'd0, carry};
  end

  always_comb begin
    // The item register is loaded at the same edge, so look at the incoming beat.
    case (item_i.kind)
      KIND_SET:                                     load_status = STATUS_FULL;
      KIND_RESTART, KIND_RESTART_LAPSE, KIND_DELETE: load_status = STATUS_NOT_FOUND;
      default:                                      load_status = STATUS_OK;
    endcase
  end

  // Evaluation of the slot whose read data sits in rd_ent_q.
  always_comb begin
    ent        = rd_vld_q ? rd_ent_q : '0;
    elapsed    = ((clock_ms_q - ent.start) >= ent.lapse);
    id_match   = (item_q.tmr_id != 8'd0) && (ent.id == item_q.tmr_id);
    freed      = '{id: 8'd0, start: 32'd0, lapse: 32'd0, mode: ent.mode};
    wr_en      = 1'b0;
    wr_ent     = ent;
    eval_hit_o = 1'b0;
    hit_status = STATUS_OK;
    query_hit  = 1'b0;
    if (ctl_i.eval_en) begin
      case (item_q.kind)
        KIND_TICK: begin
          if (ent.id != 8'd0 && elapsed && ent.mode != MODE_HOLD) begin
            wr_en = 1'b1;
            if (ent.mode == MODE_CONTINUOUS) begin
              wr_ent.start = clock_ms_q;
            end else begin
              wr_ent = freed;
            end
          end
        end
        KIND_SET: begin
          if (ent.id == 8'd0) begin
            eval_hit_o = 1'b1;
            wr_en      = 1'b1;
            wr_ent     = '{id: item_q.tmr_id, start: clock_ms_q,
                           lapse: item_q.lapse, mode: item_q.mode};
          end
        end
        KIND_QUERY: begin
          query_hit = id_match && elapsed;
        end
        KIND_RESTART, KIND_RESTART_LAPSE: begin
          if (id_match) begin
            eval_hit_o = 1'b1;
            if (ent.mode != MODE_HOLD) begin
              hit_status = STATUS_NO_RESTART;
            end else begin
              wr_en        = 1'b1;
              wr_ent.start = clock_ms_q;
              if (item_q.kind == KIND_RESTART_LAPSE) begin
                wr_ent.lapse = item_q.lapse;
              end
            end
          end
        end
        KIND_DELETE: begin
          if (id_match) begin
            eval_hit_o = 1'b1;
            wr_en      = 1'b1;
            wr_ent     = freed;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ev_idx] <= wr_ent;
    end
    if (ctl_i.rd_en) begin
      rd_ent_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= item_i;
    end
    if (ctl_i.emit) begin
      result_q.status   <= status_q;
      result_q.slot     <= slot_q;
      result_q.finished <= fin_q;
      result_q.running  <= (item_q.kind == KIND_QUERY) && !fin_q;
      result_q.now_ms   <= clock_ms_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_per_tick_q   <= 8'd1;
      frac_per_tick_q <= 8'd3;
      frac_mod_q      <= 8'd125;
      clock_ms_q      <= '0;
      clock_frac_q    <= '0;
      slot_vld_q      <= '0;
      rd_vld_q        <= 1'b0;
      status_q        <= STATUS_OK;
      slot_q          <= '0;
      fin_q           <= 1'b0;
      result_valid_q  <= 1'b0;
    end else begin
      result_valid_q <= ctl_i.emit;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MS_PER_TICK:       ms_per_tick_q   <= cfg_data_i;
          CFG_FRACTION_PER_TICK: frac_per_tick_q <= cfg_data_i;
          CFG_FRACTION_MODULUS:  frac_mod_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (ctl_i.load) begin
        status_q <= load_status;
        slot_q   <= '0;
        fin_q    <= 1'b0;
        if (item_i.kind == KIND_TICK) begin
          clock_ms_q   <= ms_next;
          clock_frac_q <= frac_next;
        end
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= slot_vld_q[rd_idx];
      end
      if (wr_en) begin
        slot_vld_q[ev_idx] <= 1'b1;
      end
      if (eval_hit_o) begin
        status_q <= hit_status;
        if (item_q.kind == KIND_SET) begin
          slot_q <= ctl_i.ev_slot;
        end
      end
      if (query_hit) begin
        fin_q <= 1'b1;
      end
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");

  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_hit_o |-> ctl_i.eval_en)
    else $error("slot hit reported outside the table walk");

  a_clock_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clock_ms_q != $past(clock_ms_q)) |-> $past(ctl_i.load && item_i.kind == KIND_TICK))
    else $error("millisecond clock moved without a tick");

endmodule
